### design/stpq_pkg.sv
// ---------------------------------------------------------------------------
// stpq_pkg
// Shared types and codes for the stable priority queue with remove by key.
// ---------------------------------------------------------------------------
package stpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SERVE  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_DROP
  } act_t;

  typedef struct packed {
    logic       capture;
    logic       scan_clr;
    logic       scan_step;
    logic       publish;
    act_t       act;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       hit;
    logic       at_end;
    logic       out_busy;
  } stat_t;

endpackage

### design/stable_priority_queue_with_remove_unit.sv
// ---------------------------------------------------------------------------
// stable_priority_queue_with_remove_unit
// Ordered table of up to 16 entries: insert by urgency, serve head, remove.
// ---------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with op, key, age and urgency. Each
// request gives one result on out_valid/out_stall: status, the served entry
// (zero unless a serve succeeded) and the occupancy after the request.
// Ops: insert, serve head, remove by key; the unused op code is a no-op.
// A request passes through the states eval, scan and finish; rejected
// requests skip the scan, a serve ends at the head, and insert and remove
// visit entries in order up to the occupied end. The scan reads one
// entry a cycle through a single read mux; the row shift on insert or
// removal is done in a single update by the whole table.
// in_stall is high from the accepted request until its result is written to
// the output register, so one request is in flight at a time; the next one
// may be accepted while the previous result is still waiting.
// A stalled receiver holds the result; a finished request then waits
// before it commits its update.
// Reset clears the occupancy count, the sequencer and out_valid; the table
// contents need no clearing since only occupied slots are read.
// ---------------------------------------------------------------------------
module stable_priority_queue_with_remove_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [31:0]                key,
  input  logic [7:0]                 age,
  input  logic [1:0]                 urgency,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [31:0]                out_key,
  output logic [7:0]                 out_age,
  output logic [1:0]                 out_urgency,
  output logic [stpq_pkg::CNT_W-1:0] occupancy
);

  stpq_pkg::cmd_t  cmd;
  stpq_pkg::stat_t stat;

  stpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  stpq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .key         (key),
    .age         (age),
    .urgency     (urgency),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_key     (out_key),
    .out_age     (out_age),
    .out_urgency (out_urgency),
    .occupancy   (occupancy),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

### design/stpq_ctrl.sv
// ---------------------------------------------------------------------------
// stpq_ctrl
// Sequencer: takes a request, walks the table and commits at most one update.
// ---------------------------------------------------------------------------
module stpq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  stpq_pkg::stat_t stat,
  output stpq_pkg::cmd_t  cmd
);

  stpq_pkg::state_t state, state_next;
  stpq_pkg::act_t   act, act_next;
  logic [1:0]       sts, sts_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stpq_pkg::S_IDLE;
      act   <= stpq_pkg::ACT_NONE;
      sts   <= stpq_pkg::ST_OK;
    end else begin
      state <= state_next;
      act   <= act_next;
      sts   <= sts_next;
    end
  end

  // next state, pending action and status
  always_comb begin
    state_next = state;
    act_next   = act;
    sts_next   = sts;
    case (state)
      stpq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stpq_pkg::S_EVAL;
        end
      end
      stpq_pkg::S_EVAL: begin
        act_next   = stpq_pkg::ACT_NONE;
        sts_next   = stpq_pkg::ST_OK;
        state_next = stpq_pkg::S_SCAN;
        case (stat.op)
          stpq_pkg::OP_INSERT: begin
            if (stat.full) begin
              sts_next   = stpq_pkg::ST_FULL;
              state_next = stpq_pkg::S_FINISH;
            end
          end
          stpq_pkg::OP_SERVE: begin
            if (stat.empty) begin
              sts_next   = stpq_pkg::ST_EMPTY;
              state_next = stpq_pkg::S_FINISH;
            end
          end
          stpq_pkg::OP_REMOVE: begin
          end
          default: begin
            state_next = stpq_pkg::S_FINISH;
          end
        endcase
      end
      stpq_pkg::S_SCAN: begin
        if (stat.at_end) begin
          state_next = stpq_pkg::S_FINISH;
          if (stat.op == stpq_pkg::OP_INSERT) begin
            act_next = stpq_pkg::ACT_INSERT;
          end else begin
            sts_next = stpq_pkg::ST_NOT_FOUND;
          end
        end else if (stat.hit) begin
          state_next = stpq_pkg::S_FINISH;
          if (stat.op == stpq_pkg::OP_INSERT) begin
            act_next = stpq_pkg::ACT_INSERT;
          end else begin
            act_next = stpq_pkg::ACT_DROP;
          end
        end
      end
      stpq_pkg::S_FINISH: begin
        if (!stat.out_busy) begin
          state_next = stpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stpq_pkg::S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    in_stall      = (state != stpq_pkg::S_IDLE);
    cmd.capture   = 1'b0;
    cmd.scan_clr  = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.publish   = 1'b0;
    cmd.act       = act;
    cmd.status    = sts;
    case (state)
      stpq_pkg::S_IDLE: begin
        cmd.capture = in_valid;
      end
      stpq_pkg::S_EVAL: begin
        cmd.scan_clr = 1'b1;
      end
      stpq_pkg::S_SCAN: begin
        cmd.scan_step = !stat.at_end && !stat.hit;
      end
      stpq_pkg::S_FINISH: begin
        cmd.publish = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/stpq_datapath.sv
// ---------------------------------------------------------------------------
// stpq_datapath
// Entry table, scan pointer, occupancy count and result register.
// ---------------------------------------------------------------------------
module stpq_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 op,
  input  logic [31:0]                key,
  input  logic [7:0]                 age,
  input  logic [1:0]                 urgency,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [31:0]                out_key,
  output logic [7:0]                 out_age,
  output logic [1:0]                 out_urgency,
  output logic [stpq_pkg::CNT_W-1:0] occupancy,
  input  stpq_pkg::cmd_t             cmd,
  output stpq_pkg::stat_t            stat
);

  logic [1:0]  req_op;
  logic [31:0] req_key;
  logic [7:0]  req_age;
  logic [1:0]  req_urg;

  logic [31:0] entry_key     [stpq_pkg::DEPTH];
  logic [7:0]  entry_age     [stpq_pkg::DEPTH];
  logic [1:0]  entry_urgency [stpq_pkg::DEPTH];

  logic [stpq_pkg::CNT_W-1:0] count, count_next;
  logic [stpq_pkg::CNT_W-1:0] idx;
  logic [stpq_pkg::IDX_W-1:0] ridx;

  logic [31:0] rd_key;
  logic [1:0]  rd_urg;
  logic        hit;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op  <= op;
      req_key <= key;
      req_age <= age;
      req_urg <= urgency;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.scan_clr) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
    end
  end

  assign ridx   = idx[stpq_pkg::IDX_W-1:0];
  assign rd_key = entry_key[ridx];
  assign rd_urg = entry_urgency[ridx];

  always_comb begin
    case (req_op)
      stpq_pkg::OP_INSERT: hit = (rd_urg < req_urg);
      stpq_pkg::OP_SERVE:  hit = 1'b1;
      stpq_pkg::OP_REMOVE: hit = (rd_key == req_key);
      default:             hit = 1'b0;
    endcase
  end

  assign stat.op       = req_op;
  assign stat.full     = (count == stpq_pkg::CNT_W'(stpq_pkg::DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.hit      = hit;
  assign stat.at_end   = (idx == count);
  assign stat.out_busy = out_valid && out_stall;

  always_comb begin
    count_next = count;
    if (cmd.publish) begin
      case (cmd.act)
        stpq_pkg::ACT_INSERT: count_next = count + 1'b1;
        stpq_pkg::ACT_DROP:   count_next = count - 1'b1;
        default:              count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // whole-row shift at the scan position
  always_ff @(posedge clk) begin
    if (cmd.publish && cmd.act == stpq_pkg::ACT_INSERT) begin
      for (int i = 1; i < stpq_pkg::DEPTH; i++) begin
        if (stpq_pkg::CNT_W'(i) > idx) begin
          entry_key[i]     <= entry_key[i-1];
          entry_age[i]     <= entry_age[i-1];
          entry_urgency[i] <= entry_urgency[i-1];
        end
      end
      for (int i = 0; i < stpq_pkg::DEPTH; i++) begin
        if (stpq_pkg::CNT_W'(i) == idx) begin
          entry_key[i]     <= req_key;
          entry_age[i]     <= req_age;
          entry_urgency[i] <= req_urg;
        end
      end
    end else if (cmd.publish && cmd.act == stpq_pkg::ACT_DROP) begin
      for (int i = 0; i < stpq_pkg::DEPTH - 1; i++) begin
        if (stpq_pkg::CNT_W'(i) >= idx) begin
          entry_key[i]     <= entry_key[i+1];
          entry_age[i]     <= entry_age[i+1];
          entry_urgency[i] <= entry_urgency[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status    <= cmd.status;
      occupancy <= count_next;
      // a served entry is always the head
      if (cmd.act == stpq_pkg::ACT_DROP && req_op == stpq_pkg::OP_SERVE) begin
        out_key     <= entry_key[0];
        out_age     <= entry_age[0];
        out_urgency <= entry_urgency[0];
      end else begin
        out_key     <= '0;
        out_age     <= '0;
        out_urgency <= '0;
      end
    end
  end

endmodule
